[rtl/nlp_pkg.sv]
// Shared types and constants for the next lexicographic permutation block.
`timescale 1ns / 1ps
`default_nettype none
package nlp_pkg;

	localparam int MAX_DIGITS_DEF = 10;
	localparam int DIGIT_W        = 4;
	localparam int SEEN_W         = 10;
	localparam int LIMIT_W        = 22;
	localparam int CHAR_W         = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_NEXT = 1'b1;

	typedef enum logic [1:0] {
		ST_DIGIT  = 2'd0,
		ST_ACCEPT = 2'd1,
		ST_BAD    = 2'd2,
		ST_NONE   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIV_INIT,
		S_PIV_SCAN,
		S_SUC_SCAN,
		S_SUC_SWAP,
		S_REV_A,
		S_REV_B,
		S_EMIT,
		S_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_ACCEPT,
		OP_PIV_INIT,
		OP_PIV_SCAN,
		OP_SUC_SCAN,
		OP_SUC_SWAP,
		OP_REV_A,
		OP_REV_B,
		OP_EMIT,
		OP_RESP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_last;
		logic req_fail;
		logic piv_lt;
		logic piv_end;
		logic suc_hit;
		logic rev_more;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

[rtl/nlp_ctrl.sv]
// Sequencing state machine for load, successor search, reversal and readout.
`timescale 1ns / 1ps
`default_nettype none
module nlp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire nlp_pkg::dp_stat_t stat,
	output nlp_pkg::dp_cmd_t      cmd,
	output logic                  ready
);
	import nlp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_IDLE;
		ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (item_valid) begin
					cmd.op = OP_ACCEPT;
					if (stat.is_load) begin
						state_d = stat.is_last ? S_RESP : S_IDLE;
					end else begin
						state_d = stat.req_fail ? S_RESP : S_PIV_INIT;
					end
				end
			end
			S_PIV_INIT: begin
				cmd.op  = OP_PIV_INIT;
				state_d = S_PIV_SCAN;
			end
			S_PIV_SCAN: begin
				cmd.op = OP_PIV_SCAN;
				if (stat.piv_lt) begin
					state_d = S_SUC_SCAN;
				end else if (stat.piv_end) begin
					state_d = S_RESP;
				end
			end
			S_SUC_SCAN: begin
				cmd.op = OP_SUC_SCAN;
				if (stat.suc_hit) begin
					state_d = S_SUC_SWAP;
				end
			end
			S_SUC_SWAP: begin
				cmd.op  = OP_SUC_SWAP;
				state_d = S_REV_A;
			end
			S_REV_A: begin
				cmd.op  = OP_REV_A;
				state_d = stat.rev_more ? S_REV_B : S_EMIT;
			end
			S_REV_B: begin
				cmd.op  = OP_REV_B;
				state_d = S_REV_A;
			end
			S_EMIT: begin
				cmd.op = OP_EMIT;
				if (stat.out_free && stat.emit_last) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				cmd.op = OP_RESP;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/nlp_dpath.sv]
// Digit store, load bookkeeping, scan pointers and the result word register.
`timescale 1ns / 1ps
`default_nettype none
module nlp_dpath #(
	parameter int MAX_DIGITS = nlp_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire nlp_pkg::dp_cmd_t               cmd,
	output nlp_pkg::dp_stat_t                   stat,
	input  wire logic                           kind,
	input  wire logic [nlp_pkg::CHAR_W-1:0]     char_code,
	input  wire logic                           last_char,
	input  wire logic                           cfg_we,
	input  wire logic [nlp_pkg::LIMIT_W-1:0]    cfg_wdata,
	input  wire logic                           result_stall,
	output logic                                result_valid,
	output nlp_pkg::status_t                    status,
	output logic [nlp_pkg::DIGIT_W-1:0]         digit,
	output logic                                last_of_run
);
	import nlp_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	logic [DIGIT_W-1:0] store_q [MAX_DIGITS];

	// Load bookkeeping and configuration.
	logic [CNT_W-1:0]   cnt_q;
	logic [SEEN_W-1:0]  seen_q;
	logic               bad_q;
	logic               valid_q;
	logic               open_q;
	logic [LIMIT_W-1:0] emitted_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               out_valid_q;

	// Scan pointers and held values.
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   piv_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [DIGIT_W-1:0] cur_q;
	logic [DIGIT_W-1:0] piv_val_q;
	logic [DIGIT_W-1:0] tmp_q;
	logic               pend_q;
	status_t            resp_q;
	status_t            out_status_q;
	logic [DIGIT_W-1:0] out_digit_q;
	logic               out_last_q;

	logic [CNT_W-1:0]   eff_cnt;
	logic [SEEN_W-1:0]  eff_seen;
	logic               eff_bad;
	logic               is_digit;
	logic [DIGIT_W-1:0] char_val;
	logic [SEEN_W-1:0]  seen_shift;
	logic               char_bad;
	logic               new_bad;
	logic               do_store;
	logic [IDX_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   k_m1;
	logic [IDX_W-1:0]   rd_idx;
	logic [DIGIT_W-1:0] rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [DIGIT_W-1:0] wr_data;
	logic               out_free;
	logic               out_load;

	// A load word that opens a new string sees cleared bookkeeping.
	assign eff_cnt    = open_q ? cnt_q : '0;
	assign eff_seen   = open_q ? seen_q : '0;
	assign eff_bad    = open_q ? bad_q : 1'b0;
	assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign char_val   = DIGIT_W'(char_code - CHAR_ZERO);
	assign seen_shift = eff_seen >> char_val;
	assign char_bad   = (eff_cnt >= CNT_W'(MAX_DIGITS)) || !is_digit || seen_shift[0];
	assign new_bad    = eff_bad || char_bad;
	assign do_store   = !char_bad;

	assign cnt_m1  = IDX_W'(cnt_q - CNT_W'(1));
	assign k_m1    = k_q - IDX_W'(1);
	assign rd_data = store_q[rd_idx];

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		unique case (cmd.op)
			OP_PIV_INIT: rd_idx = cnt_m1;
			OP_PIV_SCAN: rd_idx = k_m1;
			OP_REV_A:    rd_idx = lo_q;
			OP_REV_B:    rd_idx = hi_q;
			default:     rd_idx = k_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = k_q;
		wr_data = piv_val_q;
		out_load = 1'b0;
		unique case (cmd.op)
			OP_ACCEPT: begin
				wr_en   = (kind == KIND_LOAD) && do_store;
				wr_idx  = eff_cnt[IDX_W-1:0];
				wr_data = char_val;
			end
			OP_SUC_SCAN: begin
				wr_en   = rd_data > piv_val_q;
				wr_idx  = piv_q;
				wr_data = rd_data;
			end
			OP_SUC_SWAP: begin
				wr_en   = 1'b1;
				wr_idx  = k_q;
				wr_data = piv_val_q;
			end
			OP_REV_A: begin
				// Finish the previous swap by writing the old low digit high.
				wr_en   = pend_q;
				wr_idx  = hi_q + IDX_W'(1);
				wr_data = tmp_q;
			end
			OP_REV_B: begin
				wr_en   = 1'b1;
				wr_idx  = lo_q;
				wr_data = rd_data;
			end
			OP_EMIT: out_load = out_free;
			OP_RESP: out_load = out_free;
			default: ;
		endcase
	end

	always_comb begin
		stat.is_load   = kind == KIND_LOAD;
		stat.is_last   = last_char;
		stat.req_fail  = open_q || !valid_q || (cnt_q < CNT_W'(2)) || (emitted_q >= limit_q);
		stat.piv_lt    = rd_data < cur_q;
		stat.piv_end   = k_m1 == '0;
		stat.suc_hit   = rd_data > piv_val_q;
		stat.rev_more  = lo_q < hi_q;
		stat.emit_last = k_q == cnt_m1;
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			seen_q      <= '0;
			bad_q       <= 1'b0;
			valid_q     <= 1'b0;
			open_q      <= 1'b0;
			emitted_q   <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if ((cmd.op == OP_ACCEPT) && (kind == KIND_LOAD)) begin
				open_q  <= !last_char;
				bad_q   <= new_bad;
				valid_q <= last_char && !new_bad;
				cnt_q   <= eff_cnt + CNT_W'(do_store);
				seen_q  <= do_store ? (eff_seen | (SEEN_W'(1) << char_val)) : eff_seen;
				if (!open_q) begin
					emitted_q <= '0;
				end
			end
			if ((cmd.op == OP_PIV_SCAN) && stat.piv_lt) begin
				emitted_q <= emitted_q + LIMIT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				if (kind == KIND_LOAD) begin
					resp_q <= new_bad ? ST_BAD : ST_ACCEPT;
				end else begin
					resp_q <= ST_NONE;
				end
			end
			OP_PIV_INIT: begin
				cur_q <= rd_data;
				k_q   <= cnt_m1;
			end
			OP_PIV_SCAN: begin
				if (stat.piv_lt) begin
					piv_q     <= k_m1;
					piv_val_q <= rd_data;
					k_q       <= cnt_m1;
				end else begin
					cur_q  <= rd_data;
					k_q    <= k_m1;
					resp_q <= ST_NONE;
				end
			end
			OP_SUC_SCAN: begin
				if (!stat.suc_hit) begin
					k_q <= k_m1;
				end
			end
			OP_SUC_SWAP: begin
				lo_q   <= piv_q + IDX_W'(1);
				hi_q   <= cnt_m1;
				pend_q <= 1'b0;
			end
			OP_REV_A: begin
				pend_q <= 1'b0;
				if (stat.rev_more) begin
					tmp_q <= rd_data;
				end else begin
					k_q <= '0;
				end
			end
			OP_REV_B: begin
				lo_q   <= lo_q + IDX_W'(1);
				hi_q   <= hi_q - IDX_W'(1);
				pend_q <= 1'b1;
			end
			OP_EMIT: begin
				if (out_free) begin
					out_status_q <= ST_DIGIT;
					out_digit_q  <= rd_data;
					out_last_q   <= stat.emit_last;
					k_q          <= k_q + IDX_W'(1);
				end
			end
			OP_RESP: begin
				if (out_free) begin
					out_status_q <= resp_q;
					out_digit_q  <= '0;
					out_last_q   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign digit        = out_digit_q;
	assign last_of_run  = out_last_q;

endmodule
`default_nettype wire

[rtl/next_lexicographic_permutation.sv]
// Top level: next lexicographic permutation of a loaded decimal digit string.
//
//   channel  | handshake                  | word contents
//   item     | item_valid / item_stall    | kind, char_code, last_char
//   result   | result_valid / result_stall| status, digit, last_of_run
//   config   | cfg_we (no wait)           | cfg_wdata = perm_limit
//
// A load word is taken straight from idle; the last one then posts its response.
// A next request walks the single-read digit store: a pivot search, a successor search
// and swap, a reversal of the suffix by pair swaps, then a readout of the n stored
// digits, one result word each.
// Reset clears all bookkeeping at once; the digit store itself is never cleared.
// A stalled result holds its register, and the sequencer waits at that point.
`timescale 1ns / 1ps
`default_nettype none
module next_lexicographic_permutation #(
	parameter int MAX_DIGITS = nlp_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic                        kind,
	input  wire logic [nlp_pkg::CHAR_W-1:0]  char_code,
	input  wire logic                        last_char,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output nlp_pkg::status_t                 status,
	output logic [nlp_pkg::DIGIT_W-1:0]      digit,
	output logic                             last_of_run,
	input  wire logic                        cfg_we,
	input  wire logic [nlp_pkg::LIMIT_W-1:0] cfg_wdata
);
	import nlp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ready;

	nlp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.stat       (stat),
		.cmd        (cmd),
		.ready      (ready)
	);

	nlp_dpath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.char_code    (char_code),
		.last_char    (last_char),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.status       (status),
		.digit        (digit),
		.last_of_run  (last_of_run)
	);

	assign item_stall = !ready;

`ifndef ASSERT_OFF
	// Every response other than a digit is a one-word run with a zero digit.
	a_single_resp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_DIGIT) |-> last_of_run && (digit == '0))
		else $error("non-digit response is not a single zero word");

	// Permutation digits are always decimal.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_DIGIT) |-> (digit <= DIGIT_W'(9)))
		else $error("permutation digit out of range");

	// A load word that is not the last one never produces a word.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (kind == KIND_LOAD) && !last_char |=> !item_stall)
		else $error("sequencer left idle after a middle load word");
`endif

endmodule
`default_nettype wire

[tb/sv/next_lexicographic_permutation_test.sv]
// Self-checking testbench for the next lexicographic permutation block.
`timescale 1ns / 1ps
module next_lexicographic_permutation_test;
	import nlp_pkg::*;

	localparam int MAX_DIGITS = MAX_DIGITS_DEF;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};
	localparam int SETTLE_CYCLES = 64;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 35;

	typedef struct {
		logic              kind;
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} item_word_t;

	typedef struct {
		status_t            status;
		logic [DIGIT_W-1:0] digit;
		logic               last_of_run;
	} result_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic kind = KIND_LOAD;
	logic [CHAR_W-1:0] char_code = '0;
	logic last_char = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	status_t status;
	logic [DIGIT_W-1:0] digit;
	logic last_of_run;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	item_word_t pending_words[$];
	result_word_t owed_results[$];
	int queued_count = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic steady = 1'b0;

	// Predictor state.
	logic [DIGIT_W-1:0] m_store[MAX_DIGITS];
	int m_count = 0;
	logic [SEEN_W-1:0] m_seen = '0;
	logic m_bad = 1'b0;
	logic m_valid = 1'b0;
	logic [LIMIT_W-1:0] m_emitted = '0;
	logic m_open = 1'b0;
	logic [LIMIT_W-1:0] m_limit = '0;

	next_lexicographic_permutation #(.MAX_DIGITS(MAX_DIGITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.char_code(char_code),
		.last_char(last_char),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.digit(digit),
		.last_of_run(last_of_run),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void owe(status_t st, logic [DIGIT_W-1:0] d, logic last);
		result_word_t r;
		r.status = st;
		r.digit = d;
		r.last_of_run = last;
		owed_results.push_back(r);
	endfunction

	// Applies one accepted word to the predictor and records the results it causes.
	task automatic narayana_step(input item_word_t w);
		int p, s, lo, hi, i;
		logic [DIGIT_W-1:0] d, t;
		if (w.kind == KIND_LOAD) begin
			if (!m_open) begin
				m_open = 1'b1;
				m_count = 0;
				m_seen = '0;
				m_bad = 1'b0;
				m_valid = 1'b0;
				m_emitted = '0;
			end
			if (m_count >= MAX_DIGITS || w.char_code < CHAR_ZERO || w.char_code > CHAR_NINE) begin
				m_bad = 1'b1;
			end else begin
				d = DIGIT_W'(w.char_code - CHAR_ZERO);
				if (m_seen[d]) begin
					m_bad = 1'b1;
				end else begin
					m_seen[d] = 1'b1;
					m_store[m_count] = d;
					m_count++;
				end
			end
			if (w.last_char) begin
				m_open = 1'b0;
				m_valid = !m_bad;
				owe(m_bad ? ST_BAD : ST_ACCEPT, '0, 1'b1);
			end
		end else if (m_open || !m_valid || m_count == 0 || m_emitted >= m_limit) begin
			owe(ST_NONE, '0, 1'b1);
		end else begin
			p = m_count - 1;
			while (p > 0 && m_store[p-1] >= m_store[p])
				p--;
			if (p == 0) begin
				// Digits are already non-increasing: nothing changes.
				owe(ST_NONE, '0, 1'b1);
			end else begin
				p--;
				s = m_count - 1;
				while (s > p && m_store[s] <= m_store[p])
					s--;
				t = m_store[p];
				m_store[p] = m_store[s];
				m_store[s] = t;
				lo = p + 1;
				hi = m_count - 1;
				while (lo < hi) begin
					t = m_store[lo];
					m_store[lo] = m_store[hi];
					m_store[hi] = t;
					lo++;
					hi--;
				end
				m_emitted = m_emitted + 1'b1;
				for (i = 0; i < m_count; i++)
					owe(ST_DIGIT, m_store[i], i == m_count - 1);
			end
		end
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic queue_word(logic k, logic [CHAR_W-1:0] c, logic last);
		item_word_t w;
		w.kind = k;
		w.char_code = c;
		w.last_char = last;
		pending_words.push_back(w);
		queued_count++;
	endtask

	// The character and last flag of a request are don't-care, so they are random.
	task automatic queue_next();
		queue_word(KIND_NEXT, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic queue_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_word(KIND_LOAD, s[i], i == s.len() - 1);
	endtask

	task automatic queue_random_burst();
		logic [CHAR_W-1:0] chars[$];
		logic [DIGIT_W-1:0] pool[10];
		logic [DIGIT_W-1:0] t;
		int n, k, i, j, flavor, cut;
		for (i = 0; i < 10; i++)
			pool[i] = DIGIT_W'(i);
		for (i = 9; i > 0; i--) begin
			j = $urandom_range(i);
			t = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		n = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_DIGITS) : $urandom_range(2, 4);
		for (i = 0; i < n; i++)
			chars.push_back(CHAR_ZERO + CHAR_W'(pool[i]));
		flavor = $urandom_range(99);
		cut = -1;
		k = $urandom_range(1, 8);
		if (flavor < 70) begin
			// Well-formed string followed by a run of requests.
		end else if (flavor < 78) begin
			chars[$urandom_range(n - 1)] = CHAR_W'($urandom_range(255));
			k = $urandom_range(2);
		end else if (flavor < 84) begin
			if (n >= 2)
				chars[$urandom_range(1, n - 1)] = chars[0];
			else
				chars.push_back(chars[0]);
			k = $urandom_range(2);
		end else if (flavor < 90) begin
			// Too many characters for the store.
			for (i = n; i < 10; i++)
				chars.push_back(CHAR_ZERO + CHAR_W'(pool[i]));
			repeat ($urandom_range(1, 2))
				chars.push_back(CHAR_W'($urandom_range(255)));
			k = $urandom_range(2);
		end else if (flavor < 95) begin
			if (n >= 2)
				cut = $urandom_range(n - 2);
			k = $urandom_range(1, 3);
		end else begin
			queue_word(1'($urandom_range(1)), CHAR_W'($urandom_range(255)),
				1'($urandom_range(1)));
			return;
		end
		for (i = 0; i < chars.size(); i++) begin
			queue_word(KIND_LOAD, chars[i], i == chars.size() - 1);
			if (i == cut)
				queue_next();
		end
		repeat (k)
			queue_next();
	endtask

	// Waits until every word is taken and answered, then lets the block settle.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || item_valid || owed_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		m_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Driver: a word stays on the bus until it is taken.
	always @(posedge clk) begin : word_driver
		item_word_t on_bus;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (item_valid)
				narayana_step(on_bus);
			if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
				on_bus = pending_words.pop_front();
				item_valid <= 1'b1;
				kind <= on_bus.kind;
				char_code <= on_bus.char_code;
				last_char <= on_bus.last_char;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: compares each taken result with the oldest one owed.
	always @(posedge clk) begin : result_monitor
		result_word_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d digit %0d last %0b",
						status, digit, last_of_run));
				end else begin
					e = owed_results.pop_front();
					if (status !== e.status || digit !== e.digit || last_of_run !== e.last_of_run)
						report_mismatch($sformatf(
							"got status %0d digit %0d last %0b, want %0d %0d %0b",
							status, digit, last_of_run, e.status, e.digit, e.last_of_run));
				end
			end
			result_stall <= !steady && $urandom_range(99) < 31;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [LIMIT_W-1:0] limits[5];
		int ph, start;
		limits = '{LIMIT_W'(1), LIMIT_W'(2), LIMIT_W'(7), LIMIT_W'($urandom_range(LIMIT_MAX)),
			LIMIT_MAX};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_limit('0);

		// With a zero limit nothing may ever be emitted.
		queue_next();
		queue_text("10");
		queue_next();
		drain();
		write_limit(LIMIT_MAX);

		// Bad characters at the edges of the digit range, a repeat, and a request mid-load.
		queue_word(KIND_LOAD, 8'h00, 1'b0);
		queue_word(KIND_NEXT, 8'h00, 1'b0);
		queue_word(KIND_LOAD, 8'h2F, 1'b0);
		queue_word(KIND_LOAD, 8'h3A, 1'b0);
		queue_word(KIND_LOAD, 8'hFF, 1'b0);
		queue_word(KIND_LOAD, "5", 1'b0);
		queue_word(KIND_LOAD, "5", 1'b1);
		queue_next();
		queue_text("0123456789");
		queue_next();
		queue_text("98");
		queue_next();
		drain();

		for (ph = 0; ph < 5; ph++) begin
			write_limit(limits[ph]);
			steady = (ph == 2);
			start = queued_count;
			while (queued_count - start < PHASE_ITEMS)
				queue_random_burst();
			drain();
		end

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
